// ===== rtl/pal_pkg.sv =====
package pal_pkg;

    localparam int DEPTH       = 32;
    localparam int MAX_RESULTS = 32;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int POS_W       = 6;
    localparam int STATUS_W    = 2;
    localparam int FPOS_W      = 5;
    localparam int COUNT_OUT_W = 6;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH  = 3'd3;
    localparam logic [OP_W-1:0] OP_DISPLAY = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_WR,
        S_INS_WR,
        S_DN_RD,
        S_DN_WR,
        S_SR_RD,
        S_SR_CMP,
        S_DS_RD,
        S_DS_OUT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic [IDX_W-1:0]  rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [FPOS_W-1:0]      found_position;
        logic signed [DATA_W-1:0] entry_value;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   last;
    } result_t;

endpackage

// ===== rtl/pal_ram.sv =====
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/pal_obuf.sv =====
module pal_obuf (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  pal_pkg::result_t                    result,
    output logic                                out_free,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pal_pkg::STATUS_W-1:0]        status,
    output logic [pal_pkg::FPOS_W-1:0]          found_position,
    output logic signed [pal_pkg::DATA_W-1:0]   entry_value,
    output logic [pal_pkg::COUNT_OUT_W-1:0]     entry_count,
    output logic                                last
);

    logic             valid_reg;
    logic             valid_next;
    pal_pkg::result_t data_reg;

    assign out_free   = !valid_reg || !out_stall;
    assign valid_next = push || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= result;
        end
    end

    assign out_valid      = valid_reg;
    assign status         = data_reg.status;
    assign found_position = data_reg.found_position;
    assign entry_value    = data_reg.entry_value;
    assign entry_count    = data_reg.entry_count;
    assign last           = data_reg.last;

endmodule

// ===== rtl/pal_ctrl.sv =====
module pal_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [pal_pkg::OP_W-1:0]          operation,
    input  logic [pal_pkg::POS_W-1:0]         position,
    input  logic signed [pal_pkg::DATA_W-1:0] value,
    output pal_pkg::mem_req_t                 mem_req,
    input  logic [pal_pkg::DATA_W-1:0]        rd_data,
    input  logic                              out_free,
    output logic                              push,
    output pal_pkg::result_t                  result
);

    localparam int CNT_W = pal_pkg::CNT_W;
    localparam int IDX_W = pal_pkg::IDX_W;
    localparam int CMP_W = pal_pkg::CMP_W;

    pal_pkg::state_t                 state_reg;
    pal_pkg::state_t                 state_next;
    logic [CNT_W-1:0]                count_reg;
    logic [CNT_W-1:0]                count_next;
    logic [CNT_W-1:0]                ptr_reg;
    logic [CNT_W-1:0]                ptr_next;
    logic [pal_pkg::POS_W-1:0]       pos_reg;
    logic [pal_pkg::POS_W-1:0]       pos_next;
    logic [pal_pkg::DATA_W-1:0]      key_reg;
    logic [pal_pkg::DATA_W-1:0]      key_next;
    logic [pal_pkg::STATUS_W-1:0]    status_reg;
    logic [pal_pkg::STATUS_W-1:0]    status_next;
    logic [pal_pkg::FPOS_W-1:0]      fpos_reg;
    logic [pal_pkg::FPOS_W-1:0]      fpos_next;

    logic [CNT_W-1:0] ptr_m1;
    logic [CNT_W-1:0] ptr_m2;
    logic [CNT_W-1:0] ptr_p1;
    logic [CNT_W-1:0] ptr_p2;
    logic             count_zero;
    logic             ins_bad;
    logic             ins_at_end;
    logic             del_bad;
    logic             del_last;
    logic             up_end;
    logic             dn_end;
    logic             sr_end;
    logic             hit;
    logic             ds_last;

    assign ptr_m1 = ptr_reg - CNT_W'(1);
    assign ptr_m2 = ptr_reg - CNT_W'(2);
    assign ptr_p1 = ptr_reg + CNT_W'(1);
    assign ptr_p2 = ptr_reg + CNT_W'(2);

    assign count_zero = (count_reg == '0);
    assign ins_bad    = (CMP_W'(position) > CMP_W'(count_reg))
                        || (count_reg >= CNT_W'(pal_pkg::DEPTH));
    assign ins_at_end = (CMP_W'(position) == CMP_W'(count_reg));
    assign del_bad    = (CMP_W'(position) >= CMP_W'(count_reg));
    assign del_last   = ((CMP_W'(position) + CMP_W'(1)) == CMP_W'(count_reg));
    assign up_end     = (CMP_W'(ptr_m1) == CMP_W'(pos_reg));
    assign dn_end     = (ptr_p2 == count_reg);
    assign sr_end     = (ptr_p1 == count_reg);
    assign hit        = (rd_data == key_reg);
    assign ds_last    = (ptr_p1 == count_reg)
                        || (CMP_W'(ptr_p1) == CMP_W'(pal_pkg::MAX_RESULTS));

    assign in_stall = (state_reg != pal_pkg::S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pal_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    case (operation)
                        pal_pkg::OP_INSERT:
                        begin
                            if (ins_bad)
                            begin
                                state_next = pal_pkg::S_DONE;
                            end
                            else if (ins_at_end)
                            begin
                                state_next = pal_pkg::S_INS_WR;
                            end
                            else
                            begin
                                state_next = pal_pkg::S_UP_RD;
                            end
                        end
                        pal_pkg::OP_DELETE:
                        begin
                            state_next = (del_bad || del_last) ? pal_pkg::S_DONE
                                                               : pal_pkg::S_DN_RD;
                        end
                        pal_pkg::OP_SEARCH:
                        begin
                            state_next = count_zero ? pal_pkg::S_DONE : pal_pkg::S_SR_RD;
                        end
                        pal_pkg::OP_DISPLAY:
                        begin
                            state_next = count_zero ? pal_pkg::S_DONE : pal_pkg::S_DS_RD;
                        end
                        default:
                        begin
                            state_next = pal_pkg::S_DONE;
                        end
                    endcase
                end
            end
            pal_pkg::S_UP_RD:  state_next = pal_pkg::S_UP_WR;
            pal_pkg::S_UP_WR:  state_next = up_end ? pal_pkg::S_INS_WR : pal_pkg::S_UP_WR;
            pal_pkg::S_INS_WR: state_next = pal_pkg::S_DONE;
            pal_pkg::S_DN_RD:  state_next = pal_pkg::S_DN_WR;
            pal_pkg::S_DN_WR:  state_next = dn_end ? pal_pkg::S_DONE : pal_pkg::S_DN_WR;
            pal_pkg::S_SR_RD:  state_next = pal_pkg::S_SR_CMP;
            pal_pkg::S_SR_CMP:
            begin
                state_next = (hit || sr_end) ? pal_pkg::S_DONE : pal_pkg::S_SR_CMP;
            end
            pal_pkg::S_DS_RD:  state_next = pal_pkg::S_DS_OUT;
            pal_pkg::S_DS_OUT:
            begin
                state_next = (out_free && ds_last) ? pal_pkg::S_IDLE : pal_pkg::S_DS_OUT;
            end
            pal_pkg::S_DONE:
            begin
                state_next = out_free ? pal_pkg::S_IDLE : pal_pkg::S_DONE;
            end
            default:           state_next = pal_pkg::S_IDLE;
        endcase
    end

    // datapath and memory access
    always_comb
    begin
        ptr_next               = ptr_reg;
        count_next             = count_reg;
        pos_next               = pos_reg;
        key_next               = key_reg;
        status_next            = status_reg;
        fpos_next              = fpos_reg;
        mem_req.we             = 1'b0;
        mem_req.wr_addr        = ptr_reg[IDX_W-1:0];
        mem_req.wr_data        = rd_data;
        mem_req.rd_addr        = ptr_reg[IDX_W-1:0];
        push                   = 1'b0;
        result.status          = status_reg;
        result.found_position  = fpos_reg;
        result.entry_value     = '0;
        result.entry_count     = pal_pkg::COUNT_OUT_W'(count_reg);
        result.last            = 1'b1;
        case (state_reg)
            pal_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    pos_next    = position;
                    key_next    = value;
                    fpos_next   = '0;
                    status_next = pal_pkg::ST_OK;
                    case (operation)
                        pal_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        pal_pkg::OP_INSERT:
                        begin
                            ptr_next = count_reg;
                            if (ins_bad)
                            begin
                                status_next = pal_pkg::ST_BAD;
                            end
                        end
                        pal_pkg::OP_DELETE:
                        begin
                            ptr_next = CNT_W'(position);
                            if (del_bad)
                            begin
                                status_next = pal_pkg::ST_BAD;
                            end
                            else if (del_last)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        pal_pkg::OP_SEARCH:
                        begin
                            ptr_next = '0;
                            if (count_zero)
                            begin
                                status_next = pal_pkg::ST_NOTFOUND;
                            end
                        end
                        pal_pkg::OP_DISPLAY:
                        begin
                            ptr_next = '0;
                            if (count_zero)
                            begin
                                status_next = pal_pkg::ST_EMPTY;
                            end
                        end
                        default:
                        begin
                            status_next = pal_pkg::ST_OK;
                        end
                    endcase
                end
            end
            pal_pkg::S_UP_RD:
            begin
                mem_req.rd_addr = ptr_m1[IDX_W-1:0];
            end
            pal_pkg::S_UP_WR:
            begin
                mem_req.we      = 1'b1;
                mem_req.rd_addr = ptr_m2[IDX_W-1:0];
                ptr_next        = ptr_m1;
            end
            pal_pkg::S_INS_WR:
            begin
                mem_req.we      = 1'b1;
                mem_req.wr_addr = pos_reg[IDX_W-1:0];
                mem_req.wr_data = key_reg;
                count_next      = count_reg + CNT_W'(1);
            end
            pal_pkg::S_DN_RD:
            begin
                mem_req.rd_addr = ptr_p1[IDX_W-1:0];
            end
            pal_pkg::S_DN_WR:
            begin
                mem_req.we      = 1'b1;
                mem_req.rd_addr = ptr_p2[IDX_W-1:0];
                ptr_next        = ptr_p1;
                if (dn_end)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            pal_pkg::S_SR_RD:
            begin
                mem_req.rd_addr = ptr_reg[IDX_W-1:0];
            end
            pal_pkg::S_SR_CMP:
            begin
                mem_req.rd_addr = ptr_p1[IDX_W-1:0];
                ptr_next        = ptr_p1;
                if (hit)
                begin
                    fpos_next = pal_pkg::FPOS_W'(ptr_reg);
                end
                else if (sr_end)
                begin
                    status_next = pal_pkg::ST_NOTFOUND;
                end
            end
            pal_pkg::S_DS_RD:
            begin
                mem_req.rd_addr = ptr_reg[IDX_W-1:0];
            end
            pal_pkg::S_DS_OUT:
            begin
                push                  = out_free;
                result.status         = pal_pkg::ST_OK;
                result.found_position = pal_pkg::FPOS_W'(ptr_reg);
                result.entry_value    = $signed(rd_data);
                result.last           = ds_last;
                if (out_free)
                begin
                    mem_req.rd_addr = ptr_p1[IDX_W-1:0];
                    ptr_next        = ptr_p1;
                end
            end
            pal_pkg::S_DONE:
            begin
                push = out_free;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pal_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        fpos_reg   <= fpos_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(pal_pkg::DEPTH))
        else $error("entry count above capacity");

    a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pal_pkg::S_UP_WR || state_reg == pal_pkg::S_DN_WR)
        |-> (mem_req.rd_addr != mem_req.wr_addr))
        else $error("shift reads the entry it writes");

    a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed into a full output register");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pal_pkg::S_INS_WR) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_done_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pal_pkg::S_DONE && out_free) |=> (state_reg == pal_pkg::S_IDLE))
        else $error("sequencer stuck after final transfer");
`endif

endmodule

// ===== rtl/positional_array_list_top.sv =====
// Ordered list of up to 32 signed 32-bit values held in a single-port-read,
// single-port-write RAM with a registered read, plus an entry count. One
// operation is taken at a time; in_stall stays high until its last result has
// been loaded into the output register. Every step that walks the list moves
// one entry per cycle through the RAM read port, except that display holds
// while out_stall keeps the output register full, giving one entry per cycle
// while the output is drained. The RAM needs no clearing after reset: only
// entries below the count ever reach a result or a shift.
module positional_array_list_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pal_pkg::OP_W-1:0]            operation,
    input  logic [pal_pkg::POS_W-1:0]           position,
    input  logic signed [pal_pkg::DATA_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pal_pkg::STATUS_W-1:0]        status,
    output logic [pal_pkg::FPOS_W-1:0]          found_position,
    output logic signed [pal_pkg::DATA_W-1:0]   entry_value,
    output logic [pal_pkg::COUNT_OUT_W-1:0]     entry_count,
    output logic                                last
);

    pal_pkg::mem_req_t          mem_req;
    logic [pal_pkg::DATA_W-1:0] rd_data;
    logic                       out_free;
    logic                       push;
    pal_pkg::result_t           result;

    pal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .position  (position),
        .value     (value),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .out_free  (out_free),
        .push      (push),
        .result    (result)
    );

    pal_ram #(
        .WIDTH (pal_pkg::DATA_W),
        .DEPTH (pal_pkg::DEPTH)
    ) u_list_ram (
        .clk     (clk),
        .we      (mem_req.we),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

    pal_obuf u_obuf (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .result         (result),
        .out_free       (out_free),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found_position (found_position),
        .entry_value    (entry_value),
        .entry_count    (entry_count),
        .last           (last)
    );

endmodule

// ===== sim/positional_array_list_top_test.sv =====
`timescale 1ns / 100ps

module positional_array_list_top_test;

    localparam logic [pal_pkg::OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [pal_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [pal_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam int RANDOM_ITEMS = 95;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [pal_pkg::OP_W-1:0]          op;
        logic [pal_pkg::POS_W-1:0]         pos;
        logic signed [pal_pkg::DATA_W-1:0] val;
        logic                              typed;
        pal_pkg::result_t                  want;
    } stim_row_t;

    logic                                  clk;
    logic                                  rst_n = 1'b0;
    logic                                  in_valid = 1'b0;
    logic                                  in_stall;
    logic [pal_pkg::OP_W-1:0]              operation = '0;
    logic [pal_pkg::POS_W-1:0]             position = '0;
    logic signed [pal_pkg::DATA_W-1:0]     value = '0;
    logic                                  out_valid;
    logic                                  out_stall = 1'b0;
    logic [pal_pkg::STATUS_W-1:0]          status;
    logic [pal_pkg::FPOS_W-1:0]            found_position;
    logic signed [pal_pkg::DATA_W-1:0]     entry_value;
    logic [pal_pkg::COUNT_OUT_W-1:0]       entry_count;
    logic                                  last;

    logic signed [pal_pkg::DATA_W-1:0]     shadow_list [0:pal_pkg::DEPTH-1];
    int                                    shadow_count = 0;
    pal_pkg::result_t                      op_results [$];
    pal_pkg::result_t                      pending_results [$];
    stim_row_t                             dir_rows [$];
    pal_pkg::result_t                      want_res;
    int                                    mismatches = 0;
    int                                    results_seen = 0;
    int                                    items_sent = 0;
    bit                                    calm = 1'b0;

    positional_array_list_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .position       (position),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found_position (found_position),
        .entry_value    (entry_value),
        .entry_count    (entry_count),
        .last           (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(string msg);
        $display("%0t: result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic add_result(logic [pal_pkg::STATUS_W-1:0] st, int fpos,
                              logic signed [pal_pkg::DATA_W-1:0] val, logic lst);
        pal_pkg::result_t r;
        r.status         = st;
        r.found_position = fpos[pal_pkg::FPOS_W-1:0];
        r.entry_value    = val;
        r.entry_count    = shadow_count[pal_pkg::COUNT_OUT_W-1:0];
        r.last           = lst;
        op_results.push_back(r);
    endtask

    // list behavior after one accepted transfer
    task automatic apply_op(logic [pal_pkg::OP_W-1:0] op, logic [pal_pkg::POS_W-1:0] pos,
                            logic signed [pal_pkg::DATA_W-1:0] val);
        int  i;
        bit  hit;
        op_results = {};
        hit = 1'b0;
        case (op)
            pal_pkg::OP_CLEAR:
            begin
                shadow_count = 0;
                add_result(pal_pkg::ST_OK, 0, '0, 1'b1);
            end
            pal_pkg::OP_INSERT:
            begin
                if (int'(pos) > shadow_count || shadow_count >= pal_pkg::DEPTH)
                begin
                    add_result(pal_pkg::ST_BAD, 0, '0, 1'b1);
                end
                else
                begin
                    for (i = shadow_count; i > int'(pos); i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = val;
                    shadow_count++;
                    add_result(pal_pkg::ST_OK, 0, '0, 1'b1);
                end
            end
            pal_pkg::OP_DELETE:
            begin
                if (int'(pos) >= shadow_count)
                begin
                    add_result(pal_pkg::ST_BAD, 0, '0, 1'b1);
                end
                else
                begin
                    for (i = pos; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                    add_result(pal_pkg::ST_OK, 0, '0, 1'b1);
                end
            end
            pal_pkg::OP_SEARCH:
            begin
                for (i = 0; i < shadow_count && !hit; i++)
                begin
                    if (shadow_list[i] == val)
                    begin
                        hit = 1'b1;
                        add_result(pal_pkg::ST_OK, i, '0, 1'b1);
                    end
                end
                if (!hit)
                    add_result(pal_pkg::ST_NOTFOUND, 0, '0, 1'b1);
            end
            pal_pkg::OP_DISPLAY:
            begin
                if (shadow_count == 0)
                    add_result(pal_pkg::ST_EMPTY, 0, '0, 1'b1);
                for (i = 0; i < shadow_count && i < pal_pkg::MAX_RESULTS; i++)
                    add_result(pal_pkg::ST_OK, i, shadow_list[i],
                               (i + 1 == shadow_count) || (i + 1 == pal_pkg::MAX_RESULTS));
            end
            default:
            begin
                add_result(pal_pkg::ST_OK, 0, '0, 1'b1);
            end
        endcase
    endtask

    task automatic send_op(logic [pal_pkg::OP_W-1:0] op, logic [pal_pkg::POS_W-1:0] pos,
                           logic signed [pal_pkg::DATA_W-1:0] val, logic typed,
                           pal_pkg::result_t want);
        calm = (items_sent >= 60 && items_sent < 90);
        if (!calm && $urandom_range(0, 99) < 33)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (!calm && $urandom_range(0, 99) < 33);
        end
        in_valid  <= 1'b1;
        operation <= op;
        position  <= pos;
        value     <= val;
        do
            @(posedge clk);
        while (in_stall);
        apply_op(op, pos, val);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (op_results[k])
                pending_results.push_back(op_results[k]);
        items_sent++;
    endtask

    task automatic issue(logic [pal_pkg::OP_W-1:0] op, int pos,
                         logic signed [pal_pkg::DATA_W-1:0] val);
        send_op(op, pos[pal_pkg::POS_W-1:0], val, 1'b0, '0);
    endtask

    task automatic add_row(logic [pal_pkg::OP_W-1:0] op, int pos,
                           logic signed [pal_pkg::DATA_W-1:0] val, logic typed,
                           logic [pal_pkg::STATUS_W-1:0] st, int fpos, int cnt);
        stim_row_t r;
        r.op                  = op;
        r.pos                 = pos[pal_pkg::POS_W-1:0];
        r.val                 = val;
        r.typed               = typed;
        r.want.status         = st;
        r.want.found_position = fpos[pal_pkg::FPOS_W-1:0];
        r.want.entry_value    = '0;
        r.want.entry_count    = cnt[pal_pkg::COUNT_OUT_W-1:0];
        r.want.last           = 1'b1;
        dir_rows.push_back(r);
    endtask

    function automatic logic signed [pal_pkg::DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 32'sh7fffffff;
        if (sel == 1)
            return 32'sh80000000;
        if (sel < 5 && shadow_count > 0)
            return shadow_list[$urandom_range(0, shadow_count - 1)];
        return $urandom;
    endfunction

    task automatic fill_list();
        while (shadow_count < pal_pkg::DEPTH)
            issue(pal_pkg::OP_INSERT, $urandom_range(0, shadow_count), pick_value());
        issue(pal_pkg::OP_INSERT, $urandom_range(0, 63), pick_value());
        issue(pal_pkg::OP_DISPLAY, $urandom_range(0, 63), $urandom);
        issue(pal_pkg::OP_SEARCH, $urandom_range(0, 63), shadow_list[pal_pkg::DEPTH-1]);
        issue(pal_pkg::OP_DELETE, pal_pkg::DEPTH - 1, $urandom);
    endtask

    initial
    begin
        int sel;

        // fixed table: empty list, both value extremes, ends of the position range
        add_row(pal_pkg::OP_DISPLAY, 0,  0,             1'b1, pal_pkg::ST_EMPTY,    0, 0);
        add_row(pal_pkg::OP_SEARCH,  0,  0,             1'b1, pal_pkg::ST_NOTFOUND, 0, 0);
        add_row(pal_pkg::OP_DELETE,  0,  0,             1'b1, pal_pkg::ST_BAD,      0, 0);
        add_row(pal_pkg::OP_INSERT,  1,  5,             1'b1, pal_pkg::ST_BAD,      0, 0);
        add_row(pal_pkg::OP_INSERT,  0,  32'sh7fffffff, 1'b1, pal_pkg::ST_OK,       0, 1);
        add_row(pal_pkg::OP_INSERT,  1,  32'sh80000000, 1'b1, pal_pkg::ST_OK,       0, 2);
        add_row(pal_pkg::OP_INSERT,  0,  -32'sd1,       1'b1, pal_pkg::ST_OK,       0, 3);
        add_row(pal_pkg::OP_INSERT,  63, 0,             1'b1, pal_pkg::ST_BAD,      0, 3);
        add_row(pal_pkg::OP_INSERT,  3,  0,             1'b1, pal_pkg::ST_OK,       0, 4);
        add_row(pal_pkg::OP_SEARCH,  0,  32'sh80000000, 1'b1, pal_pkg::ST_OK,       2, 4);
        add_row(pal_pkg::OP_SEARCH,  63, -32'sd1,       1'b1, pal_pkg::ST_OK,       0, 4);
        add_row(pal_pkg::OP_SEARCH,  0,  5,             1'b1, pal_pkg::ST_NOTFOUND, 0, 4);
        add_row(pal_pkg::OP_INSERT,  1,  0,             1'b0, pal_pkg::ST_OK,       0, 0);
        add_row(pal_pkg::OP_SEARCH,  0,  0,             1'b1, pal_pkg::ST_OK,       1, 5);
        add_row(pal_pkg::OP_DISPLAY, 0,  0,             1'b0, pal_pkg::ST_OK,       0, 0);
        add_row(OP_RSVD5,            63, -32'sd1,       1'b1, pal_pkg::ST_OK,       0, 5);
        add_row(OP_RSVD6,            0,  0,             1'b1, pal_pkg::ST_OK,       0, 5);
        add_row(OP_RSVD7,            21, 32'sh55555555, 1'b1, pal_pkg::ST_OK,       0, 5);
        add_row(pal_pkg::OP_DELETE,  5,  0,             1'b1, pal_pkg::ST_BAD,      0, 5);
        add_row(pal_pkg::OP_DELETE,  63, 0,             1'b1, pal_pkg::ST_BAD,      0, 5);
        add_row(pal_pkg::OP_DELETE,  4,  0,             1'b0, pal_pkg::ST_OK,       0, 0);
        add_row(pal_pkg::OP_DELETE,  0,  0,             1'b0, pal_pkg::ST_OK,       0, 0);
        add_row(pal_pkg::OP_DISPLAY, 42, 0,             1'b0, pal_pkg::ST_OK,       0, 0);
        add_row(pal_pkg::OP_CLEAR,   0,  0,             1'b1, pal_pkg::ST_OK,       0, 0);
        add_row(pal_pkg::OP_DISPLAY, 0,  0,             1'b1, pal_pkg::ST_EMPTY,    0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < dir_rows.size(); k++)
            send_op(dir_rows[k].op, dir_rows[k].pos, dir_rows[k].val, dir_rows[k].typed,
                    dir_rows[k].want);

        fill_list();
        while (items_sent < dir_rows.size() + RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 4)
                fill_list();
            else if (sel < 20)
                issue(pal_pkg::OP_W'($urandom_range(0, 7)), $urandom_range(0, 63), $urandom);
            else if (sel < 50)
                issue(pal_pkg::OP_INSERT, $urandom_range(0, shadow_count), pick_value());
            else if (sel < 70)
                issue(pal_pkg::OP_DELETE,
                      (shadow_count > 0) ? $urandom_range(0, shadow_count - 1)
                                         : $urandom_range(0, 63), $urandom);
            else if (sel < 88)
                issue(pal_pkg::OP_SEARCH, $urandom_range(0, 63), pick_value());
            else if (sel < 97)
                issue(pal_pkg::OP_DISPLAY, $urandom_range(0, 63), $urandom);
            else
                issue(pal_pkg::OP_CLEAR, $urandom_range(0, 63), $urandom);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 33);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("transfer with nothing expected, status %0d", status));
            end
            else
            begin
                want_res = pending_results.pop_front();
                if (status !== want_res.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, want_res.status));
                if (found_position !== want_res.found_position)
                    report_mismatch($sformatf("found_position %0d, expected %0d",
                                              found_position, want_res.found_position));
                if (entry_value !== want_res.entry_value)
                    report_mismatch($sformatf("entry_value %0d, expected %0d",
                                              entry_value, want_res.entry_value));
                if (entry_count !== want_res.entry_count)
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              entry_count, want_res.entry_count));
                if (last !== want_res.last)
                    report_mismatch($sformatf("last %0d, expected %0d", last, want_res.last));
            end
            results_seen++;
        end
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pal_pkg.sv
rtl/pal_ram.sv
rtl/pal_obuf.sv
rtl/pal_ctrl.sv
rtl/positional_array_list_top.sv
sim/positional_array_list_top_test.sv
